/* design/dual_wheel_pd_speed_loop_macros.svh */
// Assertion macros shared by the speed loop RTL.
// Each macro takes a label, the clock, the active-low reset, an antecedent and a consequent.
`ifndef DUAL_WHEEL_PD_SPEED_LOOP_MACROS_SVH
`define DUAL_WHEEL_PD_SPEED_LOOP_MACROS_SVH

// Same-cycle implication.
`define DWPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("speed loop assertion failed");

// Next-cycle implication.
`define DWPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("speed loop assertion failed");

`endif

/* design/dwpd_pkg.sv */
// Package for the dual wheel PD speed loop: widths, reset values, register codes,
// microcode word format and the microcode program. No dependencies.
package dwpd_pkg;

  localparam int PWM_BITS_DEF   = 10;
  localparam int PULSE_BITS_DEF = 8;

  localparam int CMD_W    = 6;   // signed speed command
  localparam int CMDC_W   = 4;   // clamped command, 0 or 3..10
  localparam int GAIN_W   = 24;
  localparam int SCALE_W  = 16;
  localparam int START_W  = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int ERR_W   = 32;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int MA_W    = 34;   // multiplier operand A, signed
  localparam int MB_W    = GAIN_W + 1;  // multiplier operand B, signed
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int FRAC_SH = 24;
  localparam int CHG_W   = ACC_W - FRAC_SH;
  localparam int LVL_W   = CHG_W + 1;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = GAIN_W'(16384);
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = GAIN_W'(19661);
  localparam logic [SCALE_W-1:0] PULSE_SCALE_RST = SCALE_W'(2925);
  localparam logic [SCALE_W-1:0] CMD_SCALE_RST   = SCALE_W'(8774);
  localparam logic [START_W-1:0] LEFT_START_RST  = START_W'(180);
  localparam logic [START_W-1:0] RIGHT_START_RST = START_W'(200);

  localparam logic signed [CMD_W-1:0]  CMD_HI  = CMD_W'(10);
  localparam logic signed [CMD_W-1:0]  CMD_LO  = CMD_W'(3);
  localparam logic [CMDC_W-1:0]        CMDC_HI = CMDC_W'(10);
  localparam logic [CMDC_W-1:0]        CMDC_LO = CMDC_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_DERIV_GAIN  = 3'd1,
    REG_PULSE_SCALE = 3'd2,
    REG_CMD_SCALE   = 3'd3,
    REG_LEFT_START  = 3'd4,
    REG_RIGHT_START = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [SCALE_W-1:0] pulse_scale;
    logic [SCALE_W-1:0] cmd_scale;
  } cfg_regs_t;

  typedef struct packed {
    logic               left;
    logic               right;
    logic [START_W-1:0] level;
  } start_load_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_REF,
    MUL_MEAS,
    MUL_PROP,
    MUL_DERIV
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_NOP,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_ERR,
    ACT_DUTY,
    ACT_OUT
  } act_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WHEEL,
    JMP_WAIT_OUT
  } jmp_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  localparam int UC_PC_W = 4;

  localparam logic [UC_PC_W-1:0] UC_S_REF    = 4'd0;
  localparam logic [UC_PC_W-1:0] UC_S_MEAS   = 4'd1;
  localparam logic [UC_PC_W-1:0] UC_S_ERRSUB = 4'd2;
  localparam logic [UC_PC_W-1:0] UC_S_ERRSAT = 4'd3;
  localparam logic [UC_PC_W-1:0] UC_S_PROP   = 4'd4;
  localparam logic [UC_PC_W-1:0] UC_S_DERIV  = 4'd5;
  localparam logic [UC_PC_W-1:0] UC_S_SUM    = 4'd6;
  localparam logic [UC_PC_W-1:0] UC_S_DUTY   = 4'd7;
  localparam logic [UC_PC_W-1:0] UC_S_OUT    = 4'd8;
  localparam logic [UC_PC_W-1:0] UC_START    = UC_S_REF;
  localparam logic [UC_PC_W-1:0] UC_LAST     = UC_S_OUT;

  typedef struct packed {
    mul_sel_t           mul_sel;
    acc_op_t            acc_op;
    act_t               act;
    jmp_t               jmp;
    logic [UC_PC_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    logic     load_in;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    act_t     act;
    logic     wheel;
    logic     out_load;
  } dp_ctrl_t;

  // The program runs once per wheel; the duty step jumps back for the right wheel.
  function automatic ucw_t ucode(input logic [UC_PC_W-1:0] pc);
    ucw_t w;
    w = '{mul_sel: MUL_NONE, acc_op: ACC_NOP, act: ACT_NONE, jmp: JMP_NEXT, target: UC_START};
    case (pc)
      UC_S_REF:    w.mul_sel = MUL_REF;
      UC_S_MEAS: begin
        w.mul_sel = MUL_MEAS;
        w.acc_op  = ACC_LOAD;
      end
      UC_S_ERRSUB: w.acc_op = ACC_SUB;
      UC_S_ERRSAT: w.act = ACT_ERR;
      UC_S_PROP:   w.mul_sel = MUL_PROP;
      UC_S_DERIV: begin
        w.mul_sel = MUL_DERIV;
        w.acc_op  = ACC_LOAD;
      end
      UC_S_SUM:    w.acc_op = ACC_ADD;
      UC_S_DUTY: begin
        w.act    = ACT_DUTY;
        w.jmp    = JMP_WHEEL;
        w.target = UC_S_REF;
      end
      UC_S_OUT: begin
        w.act = ACT_OUT;
        w.jmp = JMP_WAIT_OUT;
      end
      default:     w.jmp = JMP_WAIT_OUT;
    endcase
    return w;
  endfunction

  // Commands above the top become the top, 1 or 2 become the floor, 0 or less become 0.
  function automatic logic [CMDC_W-1:0] clamp_command(input logic signed [CMD_W-1:0] c);
    logic [CMDC_W-1:0] r;
    if (c > CMD_HI) begin
      r = CMDC_HI;
    end else if (c <= CMD_W'(0)) begin
      r = '0;
    end else if (c < CMD_LO) begin
      r = CMDC_LO;
    end else begin
      r = c[CMDC_W-1:0];
    end
    return r;
  endfunction

endpackage

/* design/dwpd_ifs.sv */
// Channel interfaces of the speed loop: input tick, result levels, configuration writes.
// Depends on dwpd_pkg.
interface dwpd_in_if #(
  parameter int PULSE_BITS = dwpd_pkg::PULSE_BITS_DEF
);
  import dwpd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [PULSE_BITS-1:0]   left_pulses;
  logic [PULSE_BITS-1:0]   right_pulses;
  logic signed [CMD_W-1:0] left_command;
  logic signed [CMD_W-1:0] right_command;
  modport source (output valid, left_pulses, right_pulses, left_command, right_command,
                  input ready);
  modport sink (input valid, left_pulses, right_pulses, left_command, right_command,
                output ready);
endinterface

interface dwpd_out_if #(
  parameter int PWM_BITS = dwpd_pkg::PWM_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [PWM_BITS-1:0] left_level;
  logic [PWM_BITS-1:0] right_level;
  modport source (output valid, left_level, right_level, input ready);
  modport sink (input valid, left_level, right_level, output ready);
endinterface

interface dwpd_cfg_if;
  import dwpd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/dwpd_cfg_regs.sv */
// Configuration register file of the speed loop: gains and speed scales, plus
// start-level load strobes for the datapath. Depends on dwpd_pkg and dwpd_ifs.
module dwpd_cfg_regs (
  input  logic                    clk,
  input  logic                    rst_n,
  dwpd_cfg_if.sink                cfg,
  output dwpd_pkg::cfg_regs_t     regs,
  output dwpd_pkg::start_load_t   start_ld
);
  import dwpd_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;
  logic      cfg_fire;

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid && cfg.ready;

  always_comb begin
    regs_nxt       = regs_r;
    start_ld.left  = 1'b0;
    start_ld.right = 1'b0;
    start_ld.level = cfg.data[START_W-1:0];
    if (cfg_fire) begin
      case (cfg_reg_t'(cfg.index))
        REG_PROP_GAIN:   regs_nxt.prop_gain   = cfg.data[GAIN_W-1:0];
        REG_DERIV_GAIN:  regs_nxt.deriv_gain  = cfg.data[GAIN_W-1:0];
        REG_PULSE_SCALE: regs_nxt.pulse_scale = cfg.data[SCALE_W-1:0];
        REG_CMD_SCALE:   regs_nxt.cmd_scale   = cfg.data[SCALE_W-1:0];
        REG_LEFT_START:  start_ld.left  = 1'b1;
        REG_RIGHT_START: start_ld.right = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.prop_gain   <= PROP_GAIN_RST;
      regs_r.deriv_gain  <= DERIV_GAIN_RST;
      regs_r.pulse_scale <= PULSE_SCALE_RST;
      regs_r.cmd_scale   <= CMD_SCALE_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

/* design/dwpd_datapath.sv */
// Datapath of the speed loop: one shared multiplier, an accumulator, error and
// duty state per wheel, and the result registers. Depends on dwpd_pkg.
module dwpd_datapath #(
  parameter int PWM_BITS   = dwpd_pkg::PWM_BITS_DEF,
  parameter int PULSE_BITS = dwpd_pkg::PULSE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dwpd_pkg::dp_ctrl_t             ctrl,
  input  dwpd_pkg::cfg_regs_t            regs,
  input  dwpd_pkg::start_load_t          start_ld,
  input  logic [PULSE_BITS-1:0]          in_left_pulses,
  input  logic [PULSE_BITS-1:0]          in_right_pulses,
  input  logic signed [dwpd_pkg::CMD_W-1:0] in_left_command,
  input  logic signed [dwpd_pkg::CMD_W-1:0] in_right_command,
  output logic [PWM_BITS-1:0]            out_left_level,
  output logic [PWM_BITS-1:0]            out_right_level
);
  import dwpd_pkg::*;

  localparam logic [PWM_BITS-1:0] DUTY_MAX = {PWM_BITS{1'b1}};
  localparam int                  SL_W     = (PWM_BITS > START_W) ? PWM_BITS : START_W;
  localparam logic signed [ACC_W-1:0] ERR_HI = ACC_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] ERR_LO = ACC_W'(-64'sh0000_0000_8000_0000);
  localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'((64'sd1 << FRAC_SH) - 64'sd1);

  function automatic logic [PWM_BITS-1:0] clamp_start(input logic [START_W-1:0] v);
    logic [SL_W-1:0] ext;
    ext = SL_W'(v);
    return (ext > SL_W'(DUTY_MAX)) ? DUTY_MAX : ext[PWM_BITS-1:0];
  endfunction

  logic [PULSE_BITS-1:0]    pulses_r [2];
  logic [CMDC_W-1:0]        cmdc_r [2];
  logic signed [ERR_W-1:0]  prev_r [2];
  logic [PWM_BITS-1:0]      duty_r [2];
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic [PWM_BITS-1:0]      lvl_l_r;
  logic [PWM_BITS-1:0]      lvl_r_r;

  logic                     w;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ERR_W-1:0]  err_sat;
  logic signed [DIFF_W-1:0] diff_nxt;
  logic signed [ACC_W-1:0]  acc_biased;
  logic signed [CHG_W-1:0]  change;
  logic signed [LVL_W-1:0]  lvl_sum;
  logic [PWM_BITS-1:0]      duty_nxt;

  assign w = ctrl.wheel;

  // Operand selection for the one multiplier; unsigned fields enter zero-extended.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul_sel)
      MUL_REF: begin
        mul_a = MA_W'(cmdc_r[w]);
        mul_b = MB_W'(regs.cmd_scale);
      end
      MUL_MEAS: begin
        mul_a = MA_W'(pulses_r[w]);
        mul_b = MB_W'(regs.pulse_scale);
      end
      MUL_PROP: begin
        mul_a = MA_W'(err_r);
        mul_b = MB_W'(regs.prop_gain);
      end
      MUL_DERIV: begin
        mul_a = MA_W'(diff_r);
        mul_b = MB_W'(regs.deriv_gain);
      end
      default: ;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;
  assign prod_ext = ACC_W'(prod_r);

  always_comb begin
    case (ctrl.acc_op)
      ACC_LOAD: acc_nxt = prod_ext;
      ACC_ADD:  acc_nxt = acc_r + prod_ext;
      ACC_SUB:  acc_nxt = acc_r - prod_ext;
      default:  acc_nxt = acc_r;
    endcase
  end

  // The error saturates to 32 bits before it is used or kept.
  always_comb begin
    if (acc_r > ERR_HI) begin
      err_sat = ERR_W'(ERR_HI);
    end else if (acc_r < ERR_LO) begin
      err_sat = ERR_W'(ERR_LO);
    end else begin
      err_sat = acc_r[ERR_W-1:0];
    end
    diff_nxt = DIFF_W'(err_sat) - DIFF_W'(prev_r[w]);
  end

  // The level change is truncated toward zero: bias negative sums before the shift.
  always_comb begin
    acc_biased = acc_r[ACC_W-1] ? (acc_r + TRUNC_BIAS) : acc_r;
    change     = acc_biased[ACC_W-1:FRAC_SH];
    lvl_sum    = LVL_W'(signed'({1'b0, duty_r[w]})) + LVL_W'(change);
    if (lvl_sum < LVL_W'(0)) begin
      duty_nxt = '0;
    end else if (lvl_sum > LVL_W'(signed'({1'b0, DUTY_MAX}))) begin
      duty_nxt = DUTY_MAX;
    end else begin
      duty_nxt = lvl_sum[PWM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (ctrl.load_in) begin
      pulses_r[0] <= in_left_pulses;
      pulses_r[1] <= in_right_pulses;
      cmdc_r[0]   <= clamp_command(in_left_command);
      cmdc_r[1]   <= clamp_command(in_right_command);
    end
    if (ctrl.act == ACT_ERR) begin
      err_r  <= err_sat;
      diff_r <= diff_nxt;
    end
    if (ctrl.out_load) begin
      lvl_l_r <= duty_r[0];
      lvl_r_r <= duty_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r[0] <= '0;
      prev_r[1] <= '0;
      duty_r[0] <= clamp_start(LEFT_START_RST);
      duty_r[1] <= clamp_start(RIGHT_START_RST);
    end else begin
      if (ctrl.act == ACT_ERR) begin
        prev_r[w] <= err_sat;
      end
      if (start_ld.left) begin
        duty_r[0] <= clamp_start(start_ld.level);
      end else if (ctrl.act == ACT_DUTY && !w) begin
        duty_r[0] <= duty_nxt;
      end
      if (start_ld.right) begin
        duty_r[1] <= clamp_start(start_ld.level);
      end else if (ctrl.act == ACT_DUTY && w) begin
        duty_r[1] <= duty_nxt;
      end
    end
  end

  assign out_left_level  = lvl_l_r;
  assign out_right_level = lvl_r_r;

endmodule

/* design/dwpd_sequencer.sv */
// Microcode sequencer of the speed loop: step counter, wheel bit, conditional jumps,
// input handshake and result valid. Depends on dwpd_pkg and the macros header.
`include "dual_wheel_pd_speed_loop_macros.svh"

module dwpd_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output dwpd_pkg::dp_ctrl_t  ctrl
);
  import dwpd_pkg::*;

  seq_state_t         state_r;
  seq_state_t         state_nxt;
  logic [UC_PC_W-1:0] pc_r;
  logic [UC_PC_W-1:0] pc_nxt;
  logic               wheel_r;
  logic               wheel_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  ucw_t               cw;
  logic               out_free;

  assign cw       = ucode(pc_r);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_IDLE: if (in_valid) state_nxt = SEQ_RUN;
      SEQ_RUN:  if (cw.jmp == JMP_WAIT_OUT && out_free) state_nxt = SEQ_IDLE;
      default:  state_nxt = SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == SEQ_IDLE);
    ctrl          = '{load_in: 1'b0, mul_sel: MUL_NONE, acc_op: ACC_NOP, act: ACT_NONE,
                      wheel: wheel_r, out_load: 1'b0};
    ctrl.load_in  = in_valid && in_ready;
    pc_nxt        = pc_r;
    wheel_nxt     = wheel_r;
    case (state_r)
      SEQ_IDLE: begin
        pc_nxt    = UC_START;
        wheel_nxt = 1'b0;
      end
      SEQ_RUN: begin
        ctrl.mul_sel  = cw.mul_sel;
        ctrl.acc_op   = cw.acc_op;
        ctrl.out_load = (cw.act == ACT_OUT) && out_free;
        ctrl.act      = (cw.act == ACT_OUT) ? ACT_NONE : cw.act;
        case (cw.jmp)
          JMP_NEXT: pc_nxt = pc_r + UC_PC_W'(1);
          JMP_WHEEL: begin
            if (wheel_r) begin
              pc_nxt = pc_r + UC_PC_W'(1);
            end else begin
              pc_nxt    = cw.target;
              wheel_nxt = 1'b1;
            end
          end
          JMP_WAIT_OUT: pc_nxt = out_free ? UC_START : pc_r;
          default: pc_nxt = UC_START;
        endcase
      end
      default: ;
    endcase
    if (ctrl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      pc_r        <= UC_START;
      wheel_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      wheel_r     <= wheel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `DWPD_ASSERT_NEXT(a_start, clk, rst_n, in_valid && in_ready, state_r == SEQ_RUN && pc_r == UC_START && !wheel_r)
  `DWPD_ASSERT_IMPL(a_pc_range, clk, rst_n, state_r == SEQ_RUN, pc_r <= UC_LAST)
  `DWPD_ASSERT_IMPL(a_wheel_jump, clk, rst_n, $rose(wheel_r), pc_r == UC_START)
  `DWPD_ASSERT_NEXT(a_done, clk, rst_n, ctrl.out_load, state_r == SEQ_IDLE && out_valid_r)

endmodule

/* design/dual_wheel_pd_speed_loop.sv */
// Channel    Dir  Handshake      Payload
// in_ch      in   valid/ready    left_pulses, right_pulses, left_command, right_command
// out_ch     out  valid/ready    left_level, right_level
// cfg_ch     in   valid/ready    index, data (register writes, always ready)
//
// An accepted tick runs the eight per-wheel microcode steps for the left wheel, then for
// the right wheel, then one output step; the shared multiplier is busy in four steps per
// wheel. The result register is loaded at the output step, and the next tick is only taken
// once the sequencer is back in idle after that step, so no tick is taken while one is computed.
// Reset is synchronous and active-low; there is no clearing pass.
// A result that is not taken stalls the following tick at its output step; that tick is
// still accepted and computed while the result waits.
// Top level of the dual wheel PD speed loop; depends on dwpd_pkg, dwpd_ifs and the
// sequencer, datapath and configuration modules.
module dual_wheel_pd_speed_loop #(
  parameter int PWM_BITS   = dwpd_pkg::PWM_BITS_DEF,
  parameter int PULSE_BITS = dwpd_pkg::PULSE_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  dwpd_in_if.sink    in_ch,
  dwpd_out_if.source out_ch,
  dwpd_cfg_if.sink   cfg_ch
);
  import dwpd_pkg::*;

  dp_ctrl_t    ctrl;
  cfg_regs_t   regs;
  start_load_t start_ld;

  dwpd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_ch),
    .regs     (regs),
    .start_ld (start_ld)
  );

  dwpd_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctrl      (ctrl)
  );

  dwpd_datapath #(
    .PWM_BITS   (PWM_BITS),
    .PULSE_BITS (PULSE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .regs             (regs),
    .start_ld         (start_ld),
    .in_left_pulses   (in_ch.left_pulses),
    .in_right_pulses  (in_ch.right_pulses),
    .in_left_command  (in_ch.left_command),
    .in_right_command (in_ch.right_command),
    .out_left_level   (out_ch.left_level),
    .out_right_level  (out_ch.right_level)
  );

endmodule

/* bench/dual_wheel_pd_speed_loop_checker.sv */
// Result checker for the dual wheel PD speed loop: watches the tick, result and
// configuration channels, predicts both PWM levels and compares them in order.
// Depends on dwpd_pkg and the channel interfaces in dwpd_ifs.
module dual_wheel_pd_speed_loop_checker (
  input  logic clk,
  input  logic rst_n,
  dwpd_in_if   in_mon,
  dwpd_out_if  out_mon,
  dwpd_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending
);
  import dwpd_pkg::*;

  localparam longint LEVEL_MAX = (64'sd1 <<< PWM_BITS_DEF) - 64'sd1;
  localparam longint ERR_HI    = 64'sd2147483647;
  localparam longint ERR_LO    = -64'sd2147483648;
  localparam int     CMD_TOP   = 10;
  localparam int     CMD_FLOOR = 3;

  typedef struct packed {
    logic [PWM_BITS_DEF-1:0] left;
    logic [PWM_BITS_DEF-1:0] right;
  } level_pair_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic [PWM_BITS_DEF-1:0] level;
  } wheel_next_t;

  logic [GAIN_W-1:0]       prop_gain;
  logic [GAIN_W-1:0]       deriv_gain;
  logic [SCALE_W-1:0]      pulse_scale;
  logic [SCALE_W-1:0]      cmd_scale;
  logic signed [ERR_W-1:0] left_prev_err;
  logic signed [ERR_W-1:0] right_prev_err;
  logic [PWM_BITS_DEF-1:0] left_duty;
  logic [PWM_BITS_DEF-1:0] right_duty;
  level_pair_t             expected_levels[$];
  int                      mismatches = 0;

  // One incremental PD update of one wheel, on the current gains and scales.
  function automatic wheel_next_t pd_wheel_step(
    input logic [PULSE_BITS_DEF-1:0] pulses,
    input logic signed [CMD_W-1:0]   cmd,
    input logic signed [ERR_W-1:0]   prev_err,
    input logic [PWM_BITS_DEF-1:0]   duty
  );
    longint      speed_cmd;
    longint      target;
    longint      measured;
    longint      err;
    longint      change;
    longint      level;
    wheel_next_t nxt;
    if (cmd > CMD_TOP) begin
      speed_cmd = CMD_TOP;
    end else if (cmd <= 0) begin
      speed_cmd = 0;
    end else if (cmd < CMD_FLOOR) begin
      speed_cmd = CMD_FLOOR;
    end else begin
      speed_cmd = longint'(cmd);
    end
    target   = speed_cmd * longint'(cmd_scale);
    measured = longint'(pulses) * longint'(pulse_scale);
    err      = target - measured;
    if (err > ERR_HI) err = ERR_HI;
    if (err < ERR_LO) err = ERR_LO;
    change = longint'(prop_gain) * err + longint'(deriv_gain) * (err - longint'(prev_err));
    // The level change is truncated toward zero, not floored.
    if (change < 0) begin
      change = -((-change) >>> FRAC_SH);
    end else begin
      change = change >>> FRAC_SH;
    end
    level = longint'(duty) + change;
    if (level < 0) level = 0;
    if (level > LEVEL_MAX) level = LEVEL_MAX;
    nxt.err   = err[ERR_W-1:0];
    nxt.level = level[PWM_BITS_DEF-1:0];
    return nxt;
  endfunction

  always @(posedge clk) begin : monitor
    wheel_next_t lw;
    wheel_next_t rw;
    level_pair_t want;
    if (!rst_n) begin
      prop_gain      = PROP_GAIN_RST;
      deriv_gain     = DERIV_GAIN_RST;
      pulse_scale    = PULSE_SCALE_RST;
      cmd_scale      = CMD_SCALE_RST;
      left_prev_err  = '0;
      right_prev_err = '0;
      left_duty      = LEFT_START_RST;
      right_duty     = RIGHT_START_RST;
      expected_levels.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_levels.size() == 0) begin
          $display("%0t: unexpected result transaction, left %0d right %0d", $time,
                   out_mon.left_level, out_mon.right_level);
          mismatches++;
        end else begin
          want = expected_levels.pop_front();
          if (out_mon.left_level !== want.left) begin
            $display("%0t: left_level expected %0d, got %0d", $time, want.left,
                     out_mon.left_level);
            mismatches++;
          end
          if (out_mon.right_level !== want.right) begin
            $display("%0t: right_level expected %0d, got %0d", $time, want.right,
                     out_mon.right_level);
            mismatches++;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        // A start level write reloads the duty but keeps the previous error.
        case (cfg_mon.index)
          REG_PROP_GAIN:   prop_gain = cfg_mon.data[GAIN_W-1:0];
          REG_DERIV_GAIN:  deriv_gain = cfg_mon.data[GAIN_W-1:0];
          REG_PULSE_SCALE: pulse_scale = cfg_mon.data[SCALE_W-1:0];
          REG_CMD_SCALE:   cmd_scale = cfg_mon.data[SCALE_W-1:0];
          REG_LEFT_START:  left_duty = cfg_mon.data[START_W-1:0];
          REG_RIGHT_START: right_duty = cfg_mon.data[START_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        lw = pd_wheel_step(in_mon.left_pulses, in_mon.left_command, left_prev_err, left_duty);
        rw = pd_wheel_step(in_mon.right_pulses, in_mon.right_command, right_prev_err,
                           right_duty);
        left_prev_err  = lw.err;
        left_duty      = lw.level;
        right_prev_err = rw.err;
        right_duty     = rw.level;
        expected_levels.push_back('{left: lw.level, right: rw.level});
      end
    end
    fail_count <= mismatches;
    pending    <= expected_levels.size();
  end

endmodule

/* bench/dual_wheel_pd_speed_loop_test.sv */
// Top of the speed loop bench: clock, reset, tick and register stimulus, result sink,
// watchdog and verdict. Depends on dwpd_pkg, dwpd_ifs, the RTL and the checker.
module dual_wheel_pd_speed_loop_test;
  import dwpd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] SPARE_REG_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] SPARE_REG_B = 3'd7;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_AFTER     = 200;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 40;

  logic clk;
  logic rst_n;
  logic quiet = 1'b0;
  logic [SCALE_W-1:0] cur_pulse_scale = PULSE_SCALE_RST;
  logic [SCALE_W-1:0] cmd_speed_scale = CMD_SCALE_RST;
  int results_taken = 0;
  int fail_count;
  int pending;

  dwpd_in_if #(.PULSE_BITS(PULSE_BITS_DEF)) in_ch ();
  dwpd_out_if #(.PWM_BITS(PWM_BITS_DEF)) out_ch ();
  dwpd_cfg_if cfg_ch ();

  dual_wheel_pd_speed_loop #(
    .PWM_BITS  (PWM_BITS_DEF),
    .PULSE_BITS(PULSE_BITS_DEF)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  dual_wheel_pd_speed_loop_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_mon   (cfg_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) results_taken <= results_taken + 1;
  end

  // Result sink: random stalls, plus one long hold-off so the block backs up.
  initial begin : result_sink
    logic held_off;
    held_off = 1'b0;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!held_off && results_taken >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready <= quiet || ($urandom_range(99) >= 10);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_tick(input logic [PULSE_BITS_DEF-1:0] lp, input logic [PULSE_BITS_DEF-1:0] rp,
                           input logic signed [CMD_W-1:0] lc,
                           input logic signed [CMD_W-1:0] rc);
    while (!quiet && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.left_pulses   <= lp;
    in_ch.right_pulses  <= rp;
    in_ch.left_command  <= lc;
    in_ch.right_command <= rc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] pg, input logic [CFG_DATA_W-1:0] dg,
                               input logic [CFG_DATA_W-1:0] ps, input logic [CFG_DATA_W-1:0] cs,
                               input logic [CFG_DATA_W-1:0] ls,
                               input logic [CFG_DATA_W-1:0] rs);
    drain();
    write_reg(REG_PROP_GAIN, pg);
    write_reg(REG_DERIV_GAIN, dg);
    write_reg(SPARE_REG_A, 24'($urandom()));
    write_reg(REG_PULSE_SCALE, ps);
    write_reg(REG_CMD_SCALE, cs);
    write_reg(SPARE_REG_B, 24'($urandom()));
    write_reg(REG_LEFT_START, ls);
    write_reg(REG_RIGHT_START, rs);
    cfg_ch.valid <= 1'b0;
    cur_pulse_scale = ps[SCALE_W-1:0];
    cmd_speed_scale = cs[SCALE_W-1:0];
  endtask

  // Mostly a command with a pulse count near the matching speed, so the loop
  // settles and moves around the middle; the rest is unconstrained noise.
  function automatic logic [PULSE_BITS_DEF+CMD_W-1:0] rand_wheel();
    int cmd;
    int tgt;
    if ($urandom_range(99) < 65) begin
      cmd = $urandom_range(12);
      if (cur_pulse_scale == 0) begin
        tgt = $urandom_range(255);
      end else begin
        tgt = cmd * int'(cmd_speed_scale) / int'(cur_pulse_scale) + $urandom_range(8) - 4;
      end
      if (tgt < 0) tgt = 0;
      if (tgt > 255) tgt = 255;
      return {PULSE_BITS_DEF'(tgt), CMD_W'(cmd)};
    end
    return (PULSE_BITS_DEF + CMD_W)'($urandom());
  endfunction

  task automatic run_random(input int count, input int quiet_items);
    logic [PULSE_BITS_DEF-1:0] lp;
    logic [PULSE_BITS_DEF-1:0] rp;
    logic signed [CMD_W-1:0]   lc;
    logic signed [CMD_W-1:0]   rc;
    for (int i = 0; i < count; i++) begin
      quiet <= (i < quiet_items);
      {lp, lc} = rand_wheel();
      {rp, rc} = rand_wheel();
      send_tick(lp, rp, lc, rc);
    end
    quiet <= 1'b0;
  endtask

  initial begin : stimulus
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.left_pulses   = '0;
    in_ch.right_pulses  = '0;
    in_ch.left_command  = '0;
    in_ch.right_command = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed ticks on the reset settings: field extremes, every clamp region,
    // and enough drive in each direction to saturate both levels.
    send_tick(8'd0, 8'd0, 6'sd0, 6'sd0);
    send_tick(8'd255, 8'd255, 6'sd31, -6'sd32);
    repeat (5) send_tick(8'd0, 8'd0, 6'sd10, 6'sd11);
    send_tick(8'd0, 8'd0, 6'sd31, 6'sd10);
    repeat (4) send_tick(8'd255, 8'd255, 6'sd0, -6'sd1);
    send_tick(8'd255, 8'd255, -6'sd32, -6'sd16);
    send_tick(8'd3, 8'd3, 6'sd1, 6'sd2);
    send_tick(8'd6, 8'd9, 6'sd2, 6'sd1);
    send_tick(8'd9, 8'd12, 6'sd3, 6'sd4);
    send_tick(8'd30, 8'd27, 6'sd10, 6'sd9);
    send_tick(8'd128, 8'd127, -6'sd16, 6'sd15);
    send_tick(8'd1, 8'd254, 6'sd5, -6'sd5);
    send_tick(8'd21, 8'd24, 6'sd7, 6'sd8);
    send_tick(8'd18, 8'd0, 6'sd6, 6'sd3);

    apply_setting(24'($urandom_range(1 << 18)), 24'($urandom_range(1 << 18)),
                  {8'($urandom()), 16'($urandom_range(4096, 256))},
                  {8'($urandom()), 16'($urandom_range(16384, 256))},
                  24'($urandom()), 24'($urandom()));
    run_random(120, 0);

    apply_setting(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    run_random(80, 0);

    apply_setting(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0);
    run_random(30, 0);

    apply_setting(24'(PROP_GAIN_RST), 24'(DERIV_GAIN_RST),
                  {8'($urandom()), PULSE_SCALE_RST}, {8'($urandom()), CMD_SCALE_RST},
                  {14'($urandom()), LEFT_START_RST}, {14'($urandom()), RIGHT_START_RST});
    run_random(150, 80);

    apply_setting(24'($urandom()), 24'($urandom_range(1 << 20)),
                  {8'($urandom()), 16'($urandom_range(8192, 64))},
                  {8'($urandom()), 16'($urandom())},
                  24'($urandom()), 24'($urandom()));
    run_random(150, 0);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
